>>> rtl/core/ihc_pkg.sv
package ihc_pkg;

   localparam int BAD_SRC_ENTRIES  = 8;
   localparam int GOOD_DST_ENTRIES = 8;
   localparam int FIFO_DEPTH       = 4;
   localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
   localparam int MIN_HDR          = 20;
   localparam logic [16:0] POS_MAX = 17'h1FFFF;
   localparam logic [3:0]  IP_VERSION = 4'd4;

   typedef enum logic [1:0] {
      FUNC_BYTE    = 2'd0,
      FUNC_BAD_SRC = 2'd1,
      FUNC_GOOD_DST = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      VERDICT_PASS     = 3'd0,
      VERDICT_TINY     = 3'd1,
      VERDICT_VERSION  = 3'd2,
      VERDICT_HDR_LEN  = 3'd3,
      VERDICT_TOT_LEN  = 3'd4,
      VERDICT_CHECKSUM = 3'd5,
      VERDICT_SOURCE   = 3'd6
   } verdict_type;

   localparam logic [0:0] CSR_HEADER_OFFSET   = 1'd0;
   localparam logic [0:0] CSR_CHECKSUM_ENABLE = 1'd1;

   // Summary of one packet handed from the capture side to the verdict side
   typedef struct packed {
      logic [16:0] total;
      logic [7:0]  ver_ihl;
      logic [15:0] tot_len;
      logic [16:0] csum;
      logic        src_bad;
      logic        dst_good;
      logic [31:0] dest;
   } pkt_sum_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

>>> rtl/core/ipv4_header_checker.sv
// IPv4 header checker.
// req_ carries one item per transfer: a packet byte (tuser 0) or a write of
// the bad-source (1) or good-destination (2) address table. The IP header
// starts header_offset bytes into each packet. At the byte with tlast set
// the block makes one verdict and sends it on rsp_ with the header length,
// kept length, trim count, destination address and the drop counter.
// csr_ writes header_offset (index 0) and checksum_enable (index 1) and is
// always ready.
// Throughput: one item per cycle while the queue is not full. A byte is
// captured and summed in the cycle it is taken; at the last byte a packet
// summary enters a four-deep queue. The summary is written into the queue,
// then popped into the verdict register that drives rsp_tvalid; the verdict
// stage takes one summary per cycle while the receiver is ready.
// When the receiver stalls, summaries gather in the queue; req_tready falls
// only once the queue is full.
// Reset clears the table valid bits, the per-packet state, the queue, the
// drop counter and the registers to offset 0 with checksum checking on.
module ipv4_header_checker import ihc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // data_byte, entry_index, entry_addr, entry_valid
   input  logic [1:0]   req_tuser,   // func
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // verdict, header_bytes, kept_length, trim_bytes,
                                     // dest_addr, drop_count
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [7:0]   csr_data
);

   logic [7:0]      offset_ff;
   logic            csum_en_ff;
   logic            req_xfer;
   logic            push, pop;
   pkt_sum_type     push_data, pop_data;
   fifo_status_type fstat;
   logic [2:0]      verdict;
   logic [5:0]      header_bytes;
   logic [15:0]     kept_length, trim_bytes;
   logic [31:0]     dest_addr, drop_count;

   assign csr_ready  = 1'b1;
   assign req_tready = !fstat.full;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         csum_en_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_HEADER_OFFSET:   offset_ff  <= csr_data;
            CSR_CHECKSUM_ENABLE: csum_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   ihc_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_xfer), .in_func(req_tuser), .in_byte(req_tdata[7:0]),
      .in_last(req_tlast), .in_index(req_tdata[10:8]), .in_addr(req_tdata[42:11]),
      .in_entry_valid(req_tdata[43]), .header_offset(offset_ff),
      .push(push), .push_data(push_data)
   );

   ihc_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data),
      .pop(pop), .pop_data(pop_data), .status(fstat)
   );

   ihc_back u_back (
      .clock(clock), .reset(reset),
      .avail(!fstat.empty), .rec(pop_data), .pop(pop),
      .header_offset(offset_ff), .checksum_enable(csum_en_ff),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .verdict(verdict), .header_bytes(header_bytes), .kept_length(kept_length),
      .trim_bytes(trim_bytes), .dest_addr(dest_addr), .drop_count(drop_count)
   );

   assign rsp_tdata = {7'd0, drop_count, dest_addr, trim_bytes, kept_length,
                       header_bytes, verdict};

   a_fifo_state: assert property (@(posedge clock) disable iff (reset)
      !(fstat.full && fstat.empty))
      else $error("queue both full and empty");

   a_pass_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && verdict == VERDICT_PASS |-> header_bytes >= 6'(MIN_HDR))
      else $error("passing packet with short header");

   a_drop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && verdict != VERDICT_PASS |-> dest_addr == '0 && kept_length == '0)
      else $error("dropped packet carries fields");

   a_drop_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> drop_count >= $past(drop_count))
      else $error("drop counter went down");

endmodule

>>> rtl/core/ihc_front.sv
module ihc_front import ihc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [1:0]  in_func,
   input  logic [7:0]  in_byte,
   input  logic        in_last,
   input  logic [2:0]  in_index,
   input  logic [31:0] in_addr,
   input  logic        in_entry_valid,
   input  logic [7:0]  header_offset,
   output logic        push,
   output pkt_sum_type push_data
);

   logic [16:0] pos_ff, pos_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [16:0] csum_ff, csum_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [31:0] bad_addr_ff [BAD_SRC_ENTRIES];
   logic        bad_vld_ff [BAD_SRC_ENTRIES];
   logic [31:0] good_addr_ff [GOOD_DST_ENTRIES];
   logic        good_vld_ff [GOOD_DST_ENTRIES];

   logic        is_byte;
   logic        in_hdr;
   logic [16:0] k;
   logic [5:0]  hlen;
   logic [15:0] word;
   logic [17:0] s0, s1, s2;
   logic        src_hit, dst_hit;

   assign is_byte = in_valid && (func_type'(in_func) == FUNC_BYTE);

   always_comb begin
      in_hdr  = (pos_ff >= {9'd0, header_offset});
      k       = pos_ff - {9'd0, header_offset};
      vihl_in = vihl_ff;
      tlen_in = tlen_ff;
      src_in  = src_ff;
      dst_in  = dst_ff;
      csum_in = csum_ff;
      if (in_hdr) begin
         if (k == 17'd0) vihl_in = in_byte;
         else if (k == 17'd2) tlen_in = {in_byte, tlen_ff[7:0]};
         else if (k == 17'd3) tlen_in = {tlen_ff[15:8], in_byte};
         else if (k >= 17'd12 && k < 17'd16) src_in = {src_ff[23:0], in_byte};
         else if (k >= 17'd16 && k < 17'd20) dst_in = {dst_ff[23:0], in_byte};
      end
      hlen = {vihl_in[3:0], 2'b00};
      word = k[0] ? {8'd0, in_byte} : {in_byte, 8'd0};
      s0 = {1'b0, csum_ff} + {2'd0, word};
      s1 = {2'd0, s0[15:0]} + {16'd0, s0[17:16]};
      s2 = {2'd0, s1[15:0]} + {16'd0, s1[17:16]};
      if (in_hdr && k < {11'd0, hlen}) csum_in = s2[16:0];
      pos_in = (pos_ff < POS_MAX) ? pos_ff + 17'd1 : pos_ff;
   end

   always_comb begin
      src_hit = 1'b0;
      for (int i = 0; i < BAD_SRC_ENTRIES; i++)
         if (bad_vld_ff[i] && bad_addr_ff[i] == src_in) src_hit = 1'b1;
      dst_hit = 1'b0;
      for (int i = 0; i < GOOD_DST_ENTRIES; i++)
         if (good_vld_ff[i] && good_addr_ff[i] == dst_in) dst_hit = 1'b1;
   end

   assign push = is_byte && in_last;
   always_comb begin
      push_data.total    = pos_in;
      push_data.ver_ihl  = vihl_in;
      push_data.tot_len  = tlen_in;
      push_data.csum     = csum_in;
      push_data.src_bad  = src_hit;
      push_data.dst_good = dst_hit;
      push_data.dest     = dst_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         vihl_ff <= '0;
         tlen_ff <= '0;
         csum_ff <= '0;
         src_ff  <= '0;
         dst_ff  <= '0;
      end else if (is_byte) begin
         if (in_last) begin
            // clear per-packet state once the last byte is taken
            pos_ff  <= '0;
            vihl_ff <= '0;
            tlen_ff <= '0;
            csum_ff <= '0;
            src_ff  <= '0;
            dst_ff  <= '0;
         end else begin
            pos_ff  <= pos_in;
            vihl_ff <= vihl_in;
            tlen_ff <= tlen_in;
            csum_ff <= csum_in;
            src_ff  <= src_in;
            dst_ff  <= dst_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BAD_SRC_ENTRIES; i++) begin
         if (reset) begin
            bad_vld_ff[i] <= 1'b0;
         end else if (in_valid && func_type'(in_func) == FUNC_BAD_SRC
                      && {29'd0, in_index} == 32'(i)) begin
            bad_vld_ff[i]  <= in_entry_valid;
            bad_addr_ff[i] <= in_addr;
         end
      end
      for (int i = 0; i < GOOD_DST_ENTRIES; i++) begin
         if (reset) begin
            good_vld_ff[i] <= 1'b0;
         end else if (in_valid && func_type'(in_func) == FUNC_GOOD_DST
                      && {29'd0, in_index} == 32'(i)) begin
            good_vld_ff[i]  <= in_entry_valid;
            good_addr_ff[i] <= in_addr;
         end
      end
   end

endmodule

>>> rtl/core/ihc_fifo.sv
module ihc_fifo import ihc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  pkt_sum_type     push_data,
   input  logic            pop,
   output pkt_sum_type     pop_data,
   output fifo_status_type status
);

   pkt_sum_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]       wr_ff, rd_ff;
   logic [FIFO_PTR_W:0]         cnt_ff;

   assign status.full  = (cnt_ff == (FIFO_PTR_W+1)'(FIFO_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign pop_data     = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

>>> rtl/core/ihc_back.sv
module ihc_back import ihc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        avail,
   input  pkt_sum_type rec,
   output logic        pop,
   input  logic [7:0]  header_offset,
   input  logic        checksum_enable,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [2:0]  verdict,
   output logic [5:0]  header_bytes,
   output logic [15:0] kept_length,
   output logic [15:0] trim_bytes,
   output logic [31:0] dest_addr,
   output logic [31:0] drop_count
);

   logic        vld_ff;
   verdict_type vd_ff, vd_in;
   logic [5:0]  hb_ff, hb_in;
   logic [15:0] kl_ff, kl_in;
   logic [15:0] tr_ff, tr_in;
   logic [31:0] da_ff, da_in;
   logic [31:0] drop_ff, drop_in;

   logic [16:0] plen, trim;
   logic [5:0]  hlen;
   logic        short;

   assign pop = avail && (!vld_ff || out_ready);

   always_comb begin
      short = rec.total < {9'd0, header_offset};
      plen  = short ? 17'd0 : rec.total - {9'd0, header_offset};
      hlen  = {rec.ver_ihl[3:0], 2'b00};
      trim  = plen - {1'b0, rec.tot_len};
      if (short || plen < 17'(MIN_HDR))
         vd_in = VERDICT_TINY;
      else if (rec.ver_ihl[7:4] != IP_VERSION)
         vd_in = VERDICT_VERSION;
      else if (hlen < 6'(MIN_HDR))
         vd_in = VERDICT_HDR_LEN;
      else if ({1'b0, rec.tot_len} > plen || rec.tot_len < {10'd0, hlen})
         vd_in = VERDICT_TOT_LEN;
      else if (checksum_enable && rec.csum != 17'h0FFFF)
         vd_in = VERDICT_CHECKSUM;
      else if (rec.src_bad && !rec.dst_good)
         vd_in = VERDICT_SOURCE;
      else
         vd_in = VERDICT_PASS;
      if (vd_in == VERDICT_PASS) begin
         hb_in   = hlen;
         kl_in   = rec.tot_len;
         tr_in   = trim[16] ? 16'hFFFF : trim[15:0];
         da_in   = rec.dest;
         drop_in = drop_ff;
      end else begin
         hb_in   = '0;
         kl_in   = '0;
         tr_in   = '0;
         da_in   = '0;
         drop_in = (drop_ff != 32'hFFFF_FFFF) ? drop_ff + 32'd1 : drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         drop_ff <= '0;
      end else begin
         if (pop) begin
            vld_ff  <= 1'b1;
            drop_ff <= drop_in;
         end else if (out_ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         vd_ff <= vd_in;
         hb_ff <= hb_in;
         kl_ff <= kl_in;
         tr_ff <= tr_in;
         da_ff <= da_in;
      end
   end

   assign out_valid    = vld_ff;
   assign verdict      = vd_ff;
   assign header_bytes = hb_ff;
   assign kept_length  = kl_ff;
   assign trim_bytes   = tr_ff;
   assign dest_addr    = da_ff;
   assign drop_count   = drop_ff;

endmodule
